### sv/rxrf_pkg.sv
// rxrf_pkg: shared types, constants and widths for the receive ring fifo
// no dependencies; imported by every rxrf module and the top level
`timescale 1ns / 1ps

package rxrf_pkg;

    localparam int DEPTH  = 8;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } t_rx_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
        logic       overflow;
        logic       notify;
        logic [7:0] notify_target;
        logic [3:0] fill_level;
        logic [3:0] peak_level;
    } t_rx_out;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
    } t_dp_cmd;

    // datapath to controller / checks
    typedef struct packed {
        logic empty;
        logic full;
    } t_dp_status;

endpackage

### sv/rx_ring_fifo_with_notify_top.sv
// rx_ring_fifo_with_notify_top: receive ring fifo with not-empty notice
// flow: the input transfer is captured into the op and byte registers, and the
//   result is registered at the execute step; a waiting result holds the execute step
// one item in flight: a new item is taken only after the last one has executed
// reset: synchronous active-low; clears count, read position, peak, consumer id
// depends on rxrf_pkg, rxrf_ctrl, rxrf_dp
`timescale 1ns / 1ps

module rx_ring_fifo_with_notify_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rxrf_pkg::t_rx_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rxrf_pkg::t_rx_out o_out_data,
    input  logic              i_cfg_wr_en,
    input  logic [7:0]        i_cfg_wr_data
);
    import rxrf_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    rxrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    rxrf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_in_data     (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result      (o_out_data),
        .o_status      (w_status)
    );

    a_not_full_and_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_status.empty && w_status.full))
        else $error("count reads both empty and full");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken before the first executed");

    a_notify_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.notify |-> o_out_data.fill_level == 4'd1)
        else $error("notice without a fill level of one");

    a_overflow_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.overflow |-> !o_out_data.notify && !o_out_data.status)
        else $error("overflow combined with another flag");

endmodule

### sv/rxrf_ctrl.sv
// rxrf_ctrl: two-state sequencer, capture then execute, plus output valid
// depends on rxrf_pkg for the command struct
`timescale 1ns / 1ps

module rxrf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rxrf_pkg::t_dp_cmd   o_cmd
);
    import rxrf_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic w_exec;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // result slot must be free (or draining) before the item executes
    assign w_exec = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec    = w_exec;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_exec) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### sv/rxrf_dp.sv
// rxrf_dp: byte store, pointers, counters, consumer register and result register
// depends on rxrf_pkg for widths, op codes and payload structs
`timescale 1ns / 1ps

module rxrf_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rxrf_pkg::t_dp_cmd    i_cmd,
    input  rxrf_pkg::t_rx_in     i_in_data,
    input  logic                 i_cfg_wr_en,
    input  logic [7:0]           i_cfg_wr_data,
    output rxrf_pkg::t_rx_out    o_result,
    output rxrf_pkg::t_dp_status o_status
);
    import rxrf_pkg::*;

    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_rd_data;
    logic [1:0]        r_op;
    logic [7:0]        r_byte;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [ADDR_W-1:0] r_rd_pos;
    logic [ADDR_W-1:0] n_rd_pos;
    logic [CNT_W-1:0]  r_peak;
    logic [CNT_W-1:0]  n_peak;
    logic [7:0]        r_consumer;
    t_rx_out           r_result;
    t_rx_out           n_result;
    logic              w_empty;
    logic              w_full;
    logic              w_wr_en;
    logic [ADDR_W:0]   w_slot_sum;
    logic [ADDR_W-1:0] w_wr_slot;
    logic [CNT_W-1:0]  w_count_inc;

    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_count_inc = r_count + CNT_W'(1);

    // tail slot: read position plus count, wrapped once
    assign w_slot_sum = {1'b0, r_rd_pos} + (ADDR_W + 1)'(r_count);
    assign w_wr_slot  = (w_slot_sum >= (ADDR_W + 1)'(DEPTH))
                        ? ADDR_W'(w_slot_sum - (ADDR_W + 1)'(DEPTH))
                        : ADDR_W'(w_slot_sum);

    assign w_wr_en = i_cmd.exec && (r_op == OP_PUSH) && !w_full;

    always_comb begin
        n_count  = r_count;
        n_rd_pos = r_rd_pos;
        n_peak   = r_peak;
        n_result = '0;
        unique case (r_op)
            OP_PUSH: begin
                if (w_full) begin
                    n_result.overflow = 1'b1;
                end else begin
                    n_count = w_count_inc;
                    if (w_empty) begin
                        n_result.notify        = 1'b1;
                        n_result.notify_target = r_consumer;
                    end
                    if (r_peak < w_count_inc) begin
                        n_peak = w_count_inc;
                    end
                end
            end
            OP_POP: begin
                if (w_empty) begin
                    n_result.status = 1'b1;
                end else begin
                    n_result.read_data = r_rd_data;
                    n_count            = r_count - CNT_W'(1);
                    n_rd_pos = (r_rd_pos == ADDR_W'(DEPTH - 1))
                               ? '0 : r_rd_pos + ADDR_W'(1);
                end
            end
            OP_FLUSH: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        n_result.fill_level = 4'(n_count);
        n_result.peak_level = 4'(n_peak);
    end

    // byte store: one write port, registered read at the read position
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_slot] <= r_byte;
        end
        r_rd_data <= r_mem[r_rd_pos];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_in_data.operation;
            r_byte <= i_in_data.rx_byte;
        end
        if (i_cmd.exec) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_rd_pos   <= '0;
            r_peak     <= '0;
            r_consumer <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_count  <= n_count;
                r_rd_pos <= n_rd_pos;
                r_peak   <= n_peak;
            end
            if (i_cfg_wr_en) begin
                r_consumer <= i_cfg_wr_data;
            end
        end
    end

    assign o_result       = r_result;
    assign o_status.empty = w_empty;
    assign o_status.full  = w_full;

endmodule
